// ----- src/smc_pkg.sv -----
// Shared types, constants and the micro-program of the segment/mesh collision block.
package smc_pkg;

  localparam int COORD_BITS = 32;
  localparam int OVS_BITS = 16;
  localparam logic [OVS_BITS-1:0] OVS_RESET = OVS_BITS'(328);
  localparam int ACC_W = 4 * COORD_BITS + 8;
  localparam int YW = (COORD_BITS + 1 > OVS_BITS + 2) ? COORD_BITS + 1 : OVS_BITS + 2;
  localparam int NDIG = (YW + 7) / 8;
  localparam int YX = 8 * NDIG;
  localparam int DIG_W = (NDIG > 1) ? $clog2(NDIG) : 1;
  localparam int DCNT_W = $clog2(OVS_BITS);
  localparam int PC_W = 6;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [COORD_BITS:0] dif_t;
  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic signed [YX-1:0] ymul_t;

  localparam acc_t CMAX = acc_t'({1'b0, {(COORD_BITS-1){1'b1}}});
  localparam acc_t CMIN = -CMAX - acc_t'(1);

  typedef enum logic [2:0] {
    OP_EDGE, OP_DIFF, OP_MUL, OP_MAC, OP_MSB, OP_DIV, OP_END
  } opc_t;

  typedef enum logic [3:0] {
    X_E0X, X_E0Y, X_E0Z, X_N0, X_N1, X_N2, X_EN0, X_EN1, X_EN2, X_DV0, X_DV1, X_DV2
  } xsel_t;

  typedef enum logic [3:0] {
    Y_E0X, Y_E0Y, Y_E0Z, Y_E1X, Y_E1Y, Y_E1Z, Y_E2X, Y_E2Y, Y_E2Z,
    Y_D0, Y_D1, Y_D2, Y_TQ
  } ysel_t;

  typedef enum logic [4:0] {
    DST_NONE, DST_N0, DST_N1, DST_N2, DST_EN0, DST_EN1, DST_EN2, DST_A, DST_B,
    DST_CP0, DST_CP1, DST_CP2, DST_SIDE, DST_D_S1, DST_D_S2, DST_D_CP1, DST_D_CP2,
    DST_D_CP3
  } dst_t;

  typedef struct packed {
    opc_t  opc;
    xsel_t xs;
    ysel_t ys;
    dst_t  dst;
  } uop_t;

  typedef struct packed {
    logic go;
    logic wb;
    logic fin;
    logic hit;
    uop_t op;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic ab_opp;
    logic acc_neg;
  } stat_t;

  typedef struct packed {
    logic   cmd;
    coord_t ax;
    coord_t ay;
    coord_t az;
    coord_t bx;
    coord_t by;
    coord_t bz;
    coord_t cx;
    coord_t cy;
    coord_t cz;
    logic   last;
  } item_t;

  function automatic coord_t sat_coord(input acc_t v);
    coord_t r;
    if (v > CMAX) r = coord_t'(CMAX[COORD_BITS-1:0]);
    else if (v < CMIN) r = coord_t'(CMIN[COORD_BITS-1:0]);
    else r = coord_t'(v[COORD_BITS-1:0]);
    return r;
  endfunction

  function automatic uop_t mk(input opc_t o, input xsel_t x, input ysel_t y, input dst_t d);
    uop_t u;
    u.opc = o;
    u.xs = x;
    u.ys = y;
    u.dst = d;
    return u;
  endfunction

  // Normal, plane distances, hit fraction, hit point, then an edge test for each triangle edge.
  function automatic uop_t uop_rom(input logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      6'd0:  u = mk(OP_EDGE, X_E0X, Y_E0X, DST_NONE);
      6'd1:  u = mk(OP_MUL, X_E0Y, Y_E1Z, DST_NONE);
      6'd2:  u = mk(OP_MSB, X_E0Z, Y_E1Y, DST_N0);
      6'd3:  u = mk(OP_MUL, X_E0Z, Y_E1X, DST_NONE);
      6'd4:  u = mk(OP_MSB, X_E0X, Y_E1Z, DST_N1);
      6'd5:  u = mk(OP_MUL, X_E0X, Y_E1Y, DST_NONE);
      6'd6:  u = mk(OP_MSB, X_E0Y, Y_E1X, DST_N2);
      6'd7:  u = mk(OP_DIFF, X_E0X, Y_E0X, DST_D_S1);
      6'd8:  u = mk(OP_MUL, X_N0, Y_D0, DST_NONE);
      6'd9:  u = mk(OP_MAC, X_N1, Y_D1, DST_NONE);
      6'd10: u = mk(OP_MAC, X_N2, Y_D2, DST_A);
      6'd11: u = mk(OP_DIFF, X_E0X, Y_E0X, DST_D_S2);
      6'd12: u = mk(OP_MUL, X_N0, Y_D0, DST_NONE);
      6'd13: u = mk(OP_MAC, X_N1, Y_D1, DST_NONE);
      6'd14: u = mk(OP_MAC, X_N2, Y_D2, DST_B);
      6'd15: u = mk(OP_DIV, X_E0X, Y_E0X, DST_NONE);
      6'd16: u = mk(OP_MUL, X_DV0, Y_TQ, DST_CP0);
      6'd17: u = mk(OP_MUL, X_DV1, Y_TQ, DST_CP1);
      6'd18: u = mk(OP_MUL, X_DV2, Y_TQ, DST_CP2);
      6'd19: u = mk(OP_MUL, X_N1, Y_E0Z, DST_NONE);
      6'd20: u = mk(OP_MSB, X_N2, Y_E0Y, DST_EN0);
      6'd21: u = mk(OP_MUL, X_N2, Y_E0X, DST_NONE);
      6'd22: u = mk(OP_MSB, X_N0, Y_E0Z, DST_EN1);
      6'd23: u = mk(OP_MUL, X_N0, Y_E0Y, DST_NONE);
      6'd24: u = mk(OP_MSB, X_N1, Y_E0X, DST_EN2);
      6'd25: u = mk(OP_DIFF, X_E0X, Y_E0X, DST_D_CP1);
      6'd26: u = mk(OP_MUL, X_EN0, Y_D0, DST_NONE);
      6'd27: u = mk(OP_MAC, X_EN1, Y_D1, DST_NONE);
      6'd28: u = mk(OP_MAC, X_EN2, Y_D2, DST_SIDE);
      6'd29: u = mk(OP_MUL, X_N1, Y_E1Z, DST_NONE);
      6'd30: u = mk(OP_MSB, X_N2, Y_E1Y, DST_EN0);
      6'd31: u = mk(OP_MUL, X_N2, Y_E1X, DST_NONE);
      6'd32: u = mk(OP_MSB, X_N0, Y_E1Z, DST_EN1);
      6'd33: u = mk(OP_MUL, X_N0, Y_E1Y, DST_NONE);
      6'd34: u = mk(OP_MSB, X_N1, Y_E1X, DST_EN2);
      6'd35: u = mk(OP_DIFF, X_E0X, Y_E0X, DST_D_CP2);
      6'd36: u = mk(OP_MUL, X_EN0, Y_D0, DST_NONE);
      6'd37: u = mk(OP_MAC, X_EN1, Y_D1, DST_NONE);
      6'd38: u = mk(OP_MAC, X_EN2, Y_D2, DST_SIDE);
      6'd39: u = mk(OP_MUL, X_N1, Y_E2Z, DST_NONE);
      6'd40: u = mk(OP_MSB, X_N2, Y_E2Y, DST_EN0);
      6'd41: u = mk(OP_MUL, X_N2, Y_E2X, DST_NONE);
      6'd42: u = mk(OP_MSB, X_N0, Y_E2Z, DST_EN1);
      6'd43: u = mk(OP_MUL, X_N0, Y_E2Y, DST_NONE);
      6'd44: u = mk(OP_MSB, X_N1, Y_E2X, DST_EN2);
      6'd45: u = mk(OP_DIFF, X_E0X, Y_E0X, DST_D_CP3);
      6'd46: u = mk(OP_MUL, X_EN0, Y_D0, DST_NONE);
      6'd47: u = mk(OP_MAC, X_EN1, Y_D1, DST_NONE);
      6'd48: u = mk(OP_MAC, X_EN2, Y_D2, DST_SIDE);
      default: u = mk(OP_END, X_E0X, Y_E0X, DST_NONE);
    endcase
    return u;
  endfunction

endpackage

// ----- src/smc_if.sv -----
// Request, result and configuration channel interfaces of the segment/mesh collision block.
interface smc_in_if;
  logic valid;
  logic ready;
  logic cmd;
  logic signed [smc_pkg::COORD_BITS-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
  logic last;
  modport source(output valid, cmd, ax, ay, az, bx, by, bz, cx, cy, cz, last, input ready);
  modport sink(input valid, cmd, ax, ay, az, bx, by, bz, cx, cy, cz, last, output ready);
  modport mon(input valid, ready, cmd, ax, ay, az, bx, by, bz, cx, cy, cz, last);
endinterface

interface smc_out_if;
  logic valid;
  logic ready;
  logic signed [smc_pkg::COORD_BITS-1:0] px, py, pz;
  logic hit;
  logic final_res;
  modport source(output valid, px, py, pz, hit, final_res, input ready);
  modport sink(input valid, px, py, pz, hit, final_res, output ready);
  modport mon(input valid, ready, px, py, pz, hit, final_res);
endinterface

interface smc_cfg_if;
  logic valid;
  logic ready;
  logic [smc_pkg::OVS_BITS-1:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
  modport mon(input valid, ready, data);
endinterface

// ----- src/smc_ctrl.sv -----
// Sequencer that steps the datapath through the micro-program for each triangle.
module smc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_cmd,
  output logic             in_ready,
  input  logic             out_ready,
  output logic             out_valid,
  output smc_pkg::cmd_t    cmd,
  input  smc_pkg::stat_t   st
);

  typedef enum logic [2:0] {S_IDLE, S_ISSUE, S_WAIT, S_WB, S_FIN} state_t;

  state_t                      state_r;
  logic [smc_pkg::PC_W-1:0]    pc_r;
  logic                        hit_r;
  logic                        out_valid_r;
  smc_pkg::uop_t               op;

  assign op = smc_pkg::uop_rom(pc_r);
  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd = '0;
    cmd.op = op;
    cmd.hit = hit_r;
    unique case (state_r)
      S_ISSUE: begin
        case (op.opc) inside
          smc_pkg::OP_EDGE, smc_pkg::OP_DIFF, smc_pkg::OP_MUL, smc_pkg::OP_MAC,
          smc_pkg::OP_MSB: cmd.go = 1'b1;
          smc_pkg::OP_DIV: cmd.go = st.ab_opp;
          default: cmd.go = 1'b0;
        endcase
      end
      S_WB: cmd.wb = 1'b1;
      S_FIN: cmd.fin = !out_valid_r || out_ready;
      default: cmd.go = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r <= '0;
      hit_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && in_cmd) begin
            pc_r <= '0;
            state_r <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          case (op.opc) inside
            smc_pkg::OP_EDGE, smc_pkg::OP_DIFF: pc_r <= pc_r + 1'b1;
            smc_pkg::OP_MUL, smc_pkg::OP_MAC, smc_pkg::OP_MSB: state_r <= S_WAIT;
            smc_pkg::OP_DIV: begin
              if (st.ab_opp) begin
                state_r <= S_WAIT;
              end else begin
                hit_r <= 1'b0;
                state_r <= S_FIN;
              end
            end
            default: begin
              hit_r <= 1'b1;
              state_r <= S_FIN;
            end
          endcase
        end
        S_WAIT: begin
          if (st.done) begin
            if (op.dst != smc_pkg::DST_NONE) begin
              state_r <= S_WB;
            end else begin
              pc_r <= pc_r + 1'b1;
              state_r <= S_ISSUE;
            end
          end
        end
        S_WB: begin
          if (op.dst == smc_pkg::DST_SIDE && st.acc_neg) begin
            hit_r <= 1'b0;
            state_r <= S_FIN;
          end else begin
            pc_r <= pc_r + 1'b1;
            state_r <= S_ISSUE;
          end
        end
        S_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- src/smc_dpath.sv -----
// Datapath: vertex and segment registers, digit-serial multiply-accumulate and fraction divider.
module smc_dpath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_acc,
  input  smc_pkg::item_t                     item,
  input  logic                               cfg_we,
  input  logic [smc_pkg::OVS_BITS-1:0]       cfg_data,
  input  smc_pkg::cmd_t                      cmd,
  output smc_pkg::stat_t                     st,
  output smc_pkg::coord_t                    px,
  output smc_pkg::coord_t                    py,
  output smc_pkg::coord_t                    pz,
  output logic                               hit,
  output logic                               final_res
);

  localparam int W = smc_pkg::ACC_W;
  localparam int OB = smc_pkg::OVS_BITS;

  smc_pkg::coord_t t1_r[3], t2_r[3], t3_r[3], s1_r[3], s2_r[3], cp_r[3];
  smc_pkg::dif_t   e0_r[3], e1_r[3], e2_r[3], d_r[3], dv[3];
  smc_pkg::acc_t   n_r[3], en_r[3];
  smc_pkg::acc_t   a_r, b_r, acc_r, xs_r, xval, acc_step, acc_sh;
  smc_pkg::ymul_t  y_r, yval;
  logic [smc_pkg::DIG_W-1:0]  mcnt_r;
  logic [smc_pkg::DCNT_W-1:0] dcnt_r;
  logic [OB-1:0]   q_r, ovs_r;
  logic [OB:0]     tq;
  logic [W-1:0]    rem_r, den_r, rem2, a_abs, b_abs;
  logic            ge;
  logic            mul_busy_r, mul_neg_r, div_busy_r, last_r;
  logic            mul_last, div_last, mul_go, div_go;
  logic signed [8:0]   dig;
  logic signed [W+8:0] prod;
  smc_pkg::coord_t px_r, py_r, pz_r;
  logic            hit_r, final_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv[i] = smc_pkg::dif_t'(s2_r[i]) - smc_pkg::dif_t'(s1_r[i]);
    end
  end

  assign tq = {1'b0, q_r} + {1'b0, ovs_r};
  assign mul_go = cmd.go && (cmd.op.opc == smc_pkg::OP_MUL || cmd.op.opc == smc_pkg::OP_MAC ||
                             cmd.op.opc == smc_pkg::OP_MSB);
  assign div_go = cmd.go && (cmd.op.opc == smc_pkg::OP_DIV);
  assign mul_last = (mcnt_r == smc_pkg::DIG_W'(smc_pkg::NDIG - 1));
  assign div_last = (dcnt_r == smc_pkg::DCNT_W'(OB - 1));

  always_comb begin
    unique case (cmd.op.xs)
      smc_pkg::X_E0X: xval = smc_pkg::acc_t'(e0_r[0]);
      smc_pkg::X_E0Y: xval = smc_pkg::acc_t'(e0_r[1]);
      smc_pkg::X_E0Z: xval = smc_pkg::acc_t'(e0_r[2]);
      smc_pkg::X_N0:  xval = n_r[0];
      smc_pkg::X_N1:  xval = n_r[1];
      smc_pkg::X_N2:  xval = n_r[2];
      smc_pkg::X_EN0: xval = en_r[0];
      smc_pkg::X_EN1: xval = en_r[1];
      smc_pkg::X_EN2: xval = en_r[2];
      smc_pkg::X_DV0: xval = smc_pkg::acc_t'(dv[0]);
      smc_pkg::X_DV1: xval = smc_pkg::acc_t'(dv[1]);
      smc_pkg::X_DV2: xval = smc_pkg::acc_t'(dv[2]);
      default:        xval = '0;
    endcase
  end

  always_comb begin
    unique case (cmd.op.ys)
      smc_pkg::Y_E0X: yval = smc_pkg::ymul_t'(e0_r[0]);
      smc_pkg::Y_E0Y: yval = smc_pkg::ymul_t'(e0_r[1]);
      smc_pkg::Y_E0Z: yval = smc_pkg::ymul_t'(e0_r[2]);
      smc_pkg::Y_E1X: yval = smc_pkg::ymul_t'(e1_r[0]);
      smc_pkg::Y_E1Y: yval = smc_pkg::ymul_t'(e1_r[1]);
      smc_pkg::Y_E1Z: yval = smc_pkg::ymul_t'(e1_r[2]);
      smc_pkg::Y_E2X: yval = smc_pkg::ymul_t'(e2_r[0]);
      smc_pkg::Y_E2Y: yval = smc_pkg::ymul_t'(e2_r[1]);
      smc_pkg::Y_E2Z: yval = smc_pkg::ymul_t'(e2_r[2]);
      smc_pkg::Y_D0:  yval = smc_pkg::ymul_t'(d_r[0]);
      smc_pkg::Y_D1:  yval = smc_pkg::ymul_t'(d_r[1]);
      smc_pkg::Y_D2:  yval = smc_pkg::ymul_t'(d_r[2]);
      smc_pkg::Y_TQ:  yval = smc_pkg::ymul_t'($signed({1'b0, tq}));
      default:        yval = '0;
    endcase
  end

  // The top digit of the multiplier carries its sign; the others are unsigned.
  assign dig = mul_last ? $signed({y_r[7], y_r[7:0]}) : $signed({1'b0, y_r[7:0]});
  assign prod = xs_r * dig;
  assign acc_step = mul_neg_r ? acc_r - smc_pkg::acc_t'(prod) : acc_r + smc_pkg::acc_t'(prod);
  assign acc_sh = acc_r >>> OB;

  assign a_abs = a_r[W-1] ? W'(-a_r) : W'(a_r);
  assign b_abs = b_r[W-1] ? W'(-b_r) : W'(b_r);
  assign rem2 = {rem_r[W-2:0], 1'b0};
  assign ge = (rem2 >= den_r);

  assign st.done = (mul_busy_r && mul_last) || (div_busy_r && div_last);
  assign st.ab_opp = (!a_r[W-1] && (|a_r) && b_r[W-1]) || (a_r[W-1] && !b_r[W-1] && (|b_r));
  assign st.acc_neg = acc_r[W-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_busy_r <= 1'b0;
      div_busy_r <= 1'b0;
      ovs_r <= smc_pkg::OVS_RESET;
      for (int i = 0; i < 3; i++) begin
        s1_r[i] <= '0;
        s2_r[i] <= '0;
      end
    end else begin
      if (cfg_we) ovs_r <= cfg_data;
      if (in_acc && !item.cmd) begin
        s1_r[0] <= item.ax;
        s1_r[1] <= item.ay;
        s1_r[2] <= item.az;
        s2_r[0] <= item.bx;
        s2_r[1] <= item.by;
        s2_r[2] <= item.bz;
      end
      if (cmd.fin && cmd.hit) begin
        for (int i = 0; i < 3; i++) begin
          s1_r[i] <= cp_r[i];
          s2_r[i] <= cp_r[i];
        end
      end
      if (mul_go) mul_busy_r <= 1'b1;
      else if (mul_busy_r && mul_last) mul_busy_r <= 1'b0;
      if (div_go) div_busy_r <= 1'b1;
      else if (div_busy_r && div_last) div_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && item.cmd) begin
      t1_r[0] <= item.ax;
      t1_r[1] <= item.ay;
      t1_r[2] <= item.az;
      t2_r[0] <= item.bx;
      t2_r[1] <= item.by;
      t2_r[2] <= item.bz;
      t3_r[0] <= item.cx;
      t3_r[1] <= item.cy;
      t3_r[2] <= item.cz;
      last_r <= item.last;
    end
    if (cmd.go) begin
      unique case (cmd.op.opc) inside
        smc_pkg::OP_EDGE: begin
          for (int i = 0; i < 3; i++) begin
            e0_r[i] <= smc_pkg::dif_t'(t2_r[i]) - smc_pkg::dif_t'(t1_r[i]);
            e1_r[i] <= smc_pkg::dif_t'(t3_r[i]) - smc_pkg::dif_t'(t2_r[i]);
            e2_r[i] <= smc_pkg::dif_t'(t1_r[i]) - smc_pkg::dif_t'(t3_r[i]);
          end
        end
        smc_pkg::OP_DIFF: begin
          for (int i = 0; i < 3; i++) begin
            unique case (cmd.op.dst)
              smc_pkg::DST_D_S1:
                d_r[i] <= smc_pkg::dif_t'(s1_r[i]) - smc_pkg::dif_t'(t1_r[i]);
              smc_pkg::DST_D_S2:
                d_r[i] <= smc_pkg::dif_t'(s2_r[i]) - smc_pkg::dif_t'(t1_r[i]);
              smc_pkg::DST_D_CP1:
                d_r[i] <= smc_pkg::dif_t'(cp_r[i]) - smc_pkg::dif_t'(t1_r[i]);
              smc_pkg::DST_D_CP2:
                d_r[i] <= smc_pkg::dif_t'(cp_r[i]) - smc_pkg::dif_t'(t2_r[i]);
              smc_pkg::DST_D_CP3:
                d_r[i] <= smc_pkg::dif_t'(cp_r[i]) - smc_pkg::dif_t'(t3_r[i]);
              default: d_r[i] <= d_r[i];
            endcase
          end
        end
        smc_pkg::OP_DIV: begin
          rem_r <= a_abs;
          den_r <= a_abs + b_abs;
          q_r <= '0;
          dcnt_r <= '0;
        end
        smc_pkg::OP_MUL, smc_pkg::OP_MAC, smc_pkg::OP_MSB: begin
          xs_r <= xval;
          y_r <= yval;
          mcnt_r <= '0;
          mul_neg_r <= (cmd.op.opc == smc_pkg::OP_MSB);
          if (cmd.op.opc == smc_pkg::OP_MUL) acc_r <= '0;
        end
        default: begin
        end
      endcase
    end
    if (mul_busy_r) begin
      acc_r <= acc_step;
      xs_r <= {xs_r[W-9:0], 8'b0};
      y_r <= y_r >> 8;
      mcnt_r <= mcnt_r + 1'b1;
    end
    if (div_busy_r) begin
      rem_r <= ge ? rem2 - den_r : rem2;
      q_r <= {q_r[OB-2:0], ge};
      dcnt_r <= dcnt_r + 1'b1;
    end
    if (cmd.wb) begin
      unique case (cmd.op.dst)
        smc_pkg::DST_N0:  n_r[0] <= acc_r;
        smc_pkg::DST_N1:  n_r[1] <= acc_r;
        smc_pkg::DST_N2:  n_r[2] <= acc_r;
        smc_pkg::DST_EN0: en_r[0] <= acc_r;
        smc_pkg::DST_EN1: en_r[1] <= acc_r;
        smc_pkg::DST_EN2: en_r[2] <= acc_r;
        smc_pkg::DST_A:   a_r <= acc_r;
        smc_pkg::DST_B:   b_r <= acc_r;
        smc_pkg::DST_CP0: cp_r[0] <= smc_pkg::sat_coord(smc_pkg::acc_t'(s1_r[0]) + acc_sh);
        smc_pkg::DST_CP1: cp_r[1] <= smc_pkg::sat_coord(smc_pkg::acc_t'(s1_r[1]) + acc_sh);
        smc_pkg::DST_CP2: cp_r[2] <= smc_pkg::sat_coord(smc_pkg::acc_t'(s1_r[2]) + acc_sh);
        default: begin
        end
      endcase
    end
    if (cmd.fin) begin
      px_r <= cmd.hit ? cp_r[0] : s1_r[0];
      py_r <= cmd.hit ? cp_r[1] : s1_r[1];
      pz_r <= cmd.hit ? cp_r[2] : s1_r[2];
      hit_r <= cmd.hit;
      final_r <= last_r;
    end
  end

  assign px = px_r;
  assign py = py_r;
  assign pz = pz_r;
  assign hit = hit_r;
  assign final_res = final_r;

endmodule

// ----- src/segment_mesh_collision_top.sv -----
// Top level of the segment against triangle-mesh collision block.
//
//   channel   direction  carries
//   in_ch     in         cmd, ax..cz, last (segment load or triangle)
//   out_ch    out        px, py, pz, hit, final_res (one per triangle)
//   cfg_ch    in         overshoot write data
//
// A load request is taken in idle and leaves the block ready for the next request. A triangle
// request runs the micro-program and its result is registered before the next request is taken;
// the run is shorter when the segment does not cross the plane or an edge test fails.
// The shared multiplier, which consumes one 8-bit digit per cycle, sets the length of the run.
// Reset clears the segment to zero and sets overshoot to its default.
// A finished result waits in the output register while the next request is taken.
module segment_mesh_collision_top (
  input logic        clk,
  input logic        rst_n,
  smc_in_if.sink     in_ch,
  smc_out_if.source  out_ch,
  smc_cfg_if.sink    cfg_ch
);

  smc_pkg::cmd_t  cmd;
  smc_pkg::stat_t st;
  smc_pkg::item_t item;
  logic           in_ready;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready = in_ready;

  assign item.cmd = in_ch.cmd;
  assign item.ax = in_ch.ax;
  assign item.ay = in_ch.ay;
  assign item.az = in_ch.az;
  assign item.bx = in_ch.bx;
  assign item.by = in_ch.by;
  assign item.bz = in_ch.bz;
  assign item.cx = in_ch.cx;
  assign item.cy = in_ch.cy;
  assign item.cz = in_ch.cz;
  assign item.last = in_ch.last;

  smc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_cmd    (in_ch.cmd),
    .in_ready  (in_ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd),
    .st        (st)
  );

  smc_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_acc    (in_ch.valid && in_ready),
    .item      (item),
    .cfg_we    (cfg_ch.valid),
    .cfg_data  (cfg_ch.data),
    .cmd       (cmd),
    .st        (st),
    .px        (out_ch.px),
    .py        (out_ch.py),
    .pz        (out_ch.pz),
    .hit       (out_ch.hit),
    .final_res (out_ch.final_res)
  );

endmodule

// ----- src/smc_checker.sv -----
// Port-level checks on the collision block, bound to its top level.
module smc_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 in_cmd,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [smc_pkg::COORD_BITS-1:0] out_px,
  input logic signed [smc_pkg::COORD_BITS-1:0] out_py,
  input logic signed [smc_pkg::COORD_BITS-1:0] out_pz,
  input logic                                 out_hit,
  input logic                                 out_final_res
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_px) &&
    $stable(out_py) && $stable(out_pz) && $stable(out_hit) &&
    $stable(out_final_res))
    else $error("result changed while stalled");

  a_tri_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_cmd |=> !in_ready)
    else $error("request taken while a triangle is in progress");

  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_cmd && !out_valid |=> !out_valid)
    else $error("segment load produced a result");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind segment_mesh_collision_top smc_checker u_smc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .in_cmd        (in_ch.cmd),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_px        (out_ch.px),
  .out_py        (out_ch.py),
  .out_pz        (out_ch.pz),
  .out_hit       (out_ch.hit),
  .out_final_res (out_ch.final_res)
);
